/* hdl/wsr_pkg.sv */
`timescale 1ns / 1ps
package wsr_pkg;

  // Parser phases; codes above PH_PAYLOAD behave as PH_HEAD0
  typedef enum logic [2:0] {
    PH_HEAD0   = 3'd0,
    PH_HEAD1   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // Result channels
  localparam logic [1:0] CH_MSG   = 2'd0;
  localparam logic [1:0] CH_TX    = 2'd1;
  localparam logic [1:0] CH_END   = 2'd2;
  localparam logic [1:0] CH_ABORT = 2'd3;

  // Opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  // Header constants
  localparam logic [6:0] LEN_EXT16  = 7'd126;
  localparam logic [6:0] LEN_EXT64  = 7'd127;
  localparam logic [7:0] BYTE_PONG  = 8'h8A;
  localparam logic [7:0] BYTE_CLOSE = 8'h88;
  localparam logic [3:0] HC_EXT16   = 4'd2;
  localparam logic [3:0] HC_EXT64   = 4'd8;
  localparam logic [3:0] HC_MASK    = 4'd4;

  // Queue between parser and output stage
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  // All results caused by one input word
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

endpackage

/* hdl/wsr_if.sv */
`timescale 1ns / 1ps
interface wsr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface wsr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] channel;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, channel, out_byte, last, input ready);
  modport sink (input valid, channel, out_byte, last, output ready);
endinterface

/* hdl/wsr_front.sv */
`timescale 1ns / 1ps
module wsr_front #(
  parameter int LENGTH_BITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  wsr_in_if.sink           din,
  input  logic             full,
  output logic             push,
  output wsr_pkg::bundle_t push_data
);
  import wsr_pkg::*;

  localparam int LB = LENGTH_BITS;

  phase_t          phase, phase_next;
  logic [3:0]      header_count, header_count_next;
  logic [3:0]      frame_opcode;
  logic            final_flag;
  logic            mask_present, mask_present_next;
  logic [31:0]     mask_key, mask_key_next;
  logic [LB-1:0]   remaining_length, remaining_length_next;
  logic [1:0]      mask_index, mask_index_next;
  logic            message_open, message_open_next;
  logic            closing, closing_next;

  logic            fire;
  logic [7:0]      b;
  logic [6:0]      len7;
  logic            is_ext;
  logic [LB-1:0]   ext_len;
  logic [LB-1:0]   len_now;
  logic [LB-1:0]   len_dec;
  logic [3:0]      hc_dec;
  logic            hdr_done;
  logic            enter_mask;
  logic            empty;
  logic            data_op;
  logic            pay_end;
  logic [7:0]      key_byte;
  logic [7:0]      pay_byte;
  logic [1:0]      cnt;
  result_t         res0, res1;

  assign fire     = din.valid && din.ready;
  assign din.ready = !full;
  assign b        = din.rx_byte;
  assign len7     = b[6:0];
  assign is_ext   = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
  assign hc_dec   = header_count - 4'd1;
  assign len_dec  = remaining_length - LB'(1);
  assign pay_end  = (len_dec == '0);
  assign data_op  = (frame_opcode == OP_CONT) || (frame_opcode == OP_TEXT) ||
                    (frame_opcode == OP_BINARY);

  // Shift in one extended length byte, saturate on overflow
  assign ext_len = (|remaining_length[LB-1 -: 8]) ? '1 : {remaining_length[LB-9:0], b};

  // Decode header progress of the current word
  always_comb begin
    hdr_done   = 1'b0;
    enter_mask = 1'b0;
    len_now    = remaining_length;
    unique case (phase)
      PH_HEAD1: begin
        // clear the length before an extended length is shifted in
        len_now    = is_ext ? '0 : {{(LB-7){1'b0}}, len7};
        hdr_done   = !is_ext && !b[7];
        enter_mask = !is_ext && b[7];
      end
      PH_EXTLEN: begin
        len_now    = ext_len;
        hdr_done   = (hc_dec == '0) && !mask_present;
        enter_mask = (hc_dec == '0) && mask_present;
      end
      PH_MASK: begin
        hdr_done = (hc_dec == '0);
      end
      default: ;
    endcase
  end
  assign empty = (len_now == '0);

  // Select the unmask key byte, first key byte first
  always_comb begin
    case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end
  assign pay_byte = mask_present ? (b ^ key_byte) : b;

  // Next phase
  always_comb begin
    phase_next = phase;
    if (fire && !din.kind) begin
      unique case (phase)
        PH_HEAD1, PH_EXTLEN, PH_MASK: begin
          if (phase == PH_HEAD1 && is_ext) begin
            phase_next = PH_EXTLEN;
          end else if (enter_mask) begin
            phase_next = PH_MASK;
          end else if (hdr_done) begin
            phase_next = empty ? PH_HEAD0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_end) begin
            phase_next = PH_HEAD0;
          end
        end
        default: phase_next = PH_HEAD1;
      endcase
    end
  end

  // Register updates and results of the current word
  always_comb begin
    header_count_next     = header_count;
    mask_present_next     = mask_present;
    mask_key_next         = mask_key;
    remaining_length_next = remaining_length;
    mask_index_next       = mask_index;
    message_open_next     = message_open;
    closing_next          = closing;
    cnt                   = 2'd0;
    res0                  = '0;
    res1                  = '0;

    if (fire && din.kind) begin
      // Local close request
      if (!closing) begin
        res0         = '{CH_TX, BYTE_CLOSE, 1'b0};
        res1         = '{CH_TX, 8'h00, 1'b1};
        cnt          = 2'd2;
        closing_next = 1'b1;
      end
    end else if (fire) begin
      if (phase == PH_HEAD1) begin
        mask_present_next     = b[7];
        remaining_length_next = len_now;
        if (len7 == LEN_EXT16) begin
          header_count_next = HC_EXT16;
        end else if (len7 == LEN_EXT64) begin
          header_count_next = HC_EXT64;
        end
      end else if (phase == PH_EXTLEN) begin
        remaining_length_next = ext_len;
        header_count_next     = hc_dec;
      end else if (phase == PH_MASK) begin
        mask_key_next     = {mask_key[23:0], b};
        header_count_next = hc_dec;
      end

      if (enter_mask) begin
        mask_key_next     = '0;
        header_count_next = HC_MASK;
      end

      if (hdr_done) begin
        mask_index_next = 2'd0;
        if (data_op) begin
          message_open_next = 1'b1;
          if (frame_opcode != OP_CONT && message_open) begin
            res0 = '{CH_ABORT, 8'h00, 1'b0};
            cnt  = 2'd1;
          end
          if (empty && final_flag) begin
            if (cnt == 2'd0) begin
              res0 = '{CH_END, 8'h00, 1'b1};
            end else begin
              res1 = '{CH_END, 8'h00, 1'b1};
            end
            cnt               = cnt + 2'd1;
            message_open_next = 1'b0;
          end
        end else if (frame_opcode == OP_PING) begin
          res0 = '{CH_TX, BYTE_PONG, 1'b0};
          res1 = '{CH_TX, len_now[7:0], empty};
          cnt  = 2'd2;
        end else if (frame_opcode == OP_CLOSE && !closing) begin
          res0         = '{CH_TX, BYTE_CLOSE, 1'b0};
          res1         = '{CH_TX, 8'h00, 1'b1};
          cnt          = 2'd2;
          closing_next = 1'b1;
        end
      end

      if (phase == PH_PAYLOAD) begin
        mask_index_next       = mask_index + 2'd1;
        remaining_length_next = len_dec;
        if (data_op) begin
          res0 = '{CH_MSG, pay_byte, pay_end && final_flag};
          cnt  = 2'd1;
          if (pay_end && final_flag) begin
            message_open_next = 1'b0;
          end
        end else if (frame_opcode == OP_PING) begin
          res0 = '{CH_TX, pay_byte, pay_end};
          cnt  = 2'd1;
        end
      end
    end
  end

  assign push           = fire && (cnt != 2'd0);
  assign push_data.two  = (cnt == 2'd2);
  assign push_data.r0   = res0;
  assign push_data.r1   = res1;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD0;
      header_count <= '0;
      frame_opcode <= '0;
      final_flag   <= 1'b0;
      mask_present <= 1'b0;
      mask_index   <= '0;
      message_open <= 1'b0;
      closing      <= 1'b0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      mask_present <= mask_present_next;
      mask_index   <= mask_index_next;
      message_open <= message_open_next;
      closing      <= closing_next;
      if (fire && !din.kind && phase != PH_HEAD1 && phase != PH_EXTLEN &&
          phase != PH_MASK && phase != PH_PAYLOAD) begin
        final_flag   <= b[7];
        frame_opcode <= b[3:0];
      end
    end
  end

  // Length and key carry no reset
  always_ff @(posedge clk) begin
    remaining_length <= remaining_length_next;
    mask_key         <= mask_key_next;
  end

  a_closing_sticky: assert property (@(posedge clk) disable iff (rst)
    ($past(closing) && !$past(rst)) |-> closing)
    else $error("closing state cleared without reset");

  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining_length != '0))
    else $error("payload phase with zero remaining length");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EXTLEN || phase == PH_MASK) |-> (header_count != '0))
    else $error("header byte phase with no bytes due");

endmodule

/* hdl/wsr_queue.sv */
`timescale 1ns / 1ps
module wsr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wsr_pkg::bundle_t push_data,
  input  logic             pop,
  output wsr_pkg::bundle_t pop_data,
  output logic             full,
  output logic             empty
);
  import wsr_pkg::*;

  bundle_t           entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Store pushed bundles
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue pushed while full or popped while empty");

endmodule

/* hdl/wsr_back.sv */
`timescale 1ns / 1ps
module wsr_back (
  input  logic             clk,
  input  logic             rst,
  input  wsr_pkg::bundle_t pop_data,
  input  logic             empty,
  output logic             pop,
  wsr_out_if.source        dout
);
  import wsr_pkg::*;

  logic    out_valid;
  result_t out_res;
  logic    pend_valid;
  result_t pend_res;
  logic    load;

  assign load = !out_valid || dout.ready;
  assign pop  = load && !pend_valid && !empty;

  assign dout.valid    = out_valid;
  assign dout.channel  = out_res.channel;
  assign dout.out_byte = out_res.out_byte;
  assign dout.last     = out_res.last;

  // Control: output word valid and pending second result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!empty) begin
        out_valid  <= 1'b1;
        pend_valid <= pop_data.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: load next word
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_res <= pend_res;
      end else if (!empty) begin
        out_res  <= pop_data.r0;
        pend_res <= pop_data.r1;
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("second result pending with no word on output");

endmodule

/* hdl/websocket_frame_receiver_core.sv */
`timescale 1ns / 1ps
// Path: a result word goes through a queue entry into the output register that drives dout.
// Throughput: one input word per cycle while the queue is not full; the output register
//   sends one word per cycle while dout is ready, so an input word that causes two results
//   (pong or close reply, abort plus end) puts them on dout one after the other.
//   A four-entry queue decouples parser and output.
// Reset: synchronous, active high; parser returns to the first header byte, connection open.
module websocket_frame_receiver_core #(
  parameter int LENGTH_BITS = 64
) (
  input logic       clk,
  input logic       rst,
  wsr_in_if.sink    din,
  wsr_out_if.source dout
);
  import wsr_pkg::*;

  logic    push;
  bundle_t push_data;
  logic    pop;
  bundle_t pop_data;
  logic    full;
  logic    empty;

  wsr_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .full     (full),
    .push     (push),
    .push_data(push_data)
  );

  wsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (full),
    .empty    (empty)
  );

  wsr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .pop_data(pop_data),
    .empty   (empty),
    .pop     (pop),
    .dout    (dout)
  );

endmodule
